>>> design/cual_pkg.sv
// Shared types and constants for the card identifier allow-list.
package cual_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int ID_BYTES    = 4;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [31:0] ID_MASK = (ID_BYTES >= 4) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << (8 * ID_BYTES)) - 64'd1);

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_PRESENT   = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] card_id;
   } req_type;

   typedef struct packed {
      logic       success;
      logic [1:0] status;
      logic [4:0] stored_count;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [31:0]      data;
   } wr_type;

endpackage

>>> design/cual_table.sv
// Identifier table: one write port, one registered read port.
module cual_table
   import cual_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [31:0]      rd_data,
   input  wr_type           wr
);

   logic [31:0] mem [MAX_ENTRIES];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/card_uid_allow_list_top.sv
// Top level of the card identifier allow-list: request sequencer and count.
// With an empty list the response is registered straight from accept; otherwise the
//   sequencer scans in ST_SCAN, and a remove that hits also passes through ST_MOVE.
// One request at a time (start is taken only in idle); the scan reads one table entry
//   per cycle through the single read port.
// Reset clears the count and the sequencer; no table clearing pass is needed.
// rsp_strobe lasts one cycle and the receiver cannot stall it.
module card_uid_allow_list_top
   import cual_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_MOVE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       kind_ff, kind_in;
   logic [31:0]      id_ff, id_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      rd_data;
   wr_type           wr;

   // Miss handling is shared between an empty list at accept and the end of a scan.
   logic             do_miss;
   logic [1:0]       miss_kind;
   logic [31:0]      miss_id;
   logic             hit;
   logic             last;

   cual_table u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   assign hit  = (rd_data & ID_MASK) == (id_ff & ID_MASK);
   assign last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = '0;
      wr            = '0;
      do_miss       = 1'b0;
      miss_kind     = kind_ff;
      miss_id       = id_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in = req_data.kind;
               id_in   = req_data.card_id;
               idx_in  = '0;
               if (count_ff == '0) begin
                  // Empty list: nothing to scan, answer now.
                  do_miss   = 1'b1;
                  miss_kind = req_data.kind;
                  miss_id   = req_data.card_id;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               pos_in = idx_ff;
               if (kind_ff == KIND_REMOVE) begin
                  // Fetch the last entry to move into the hole.
                  rd_addr  = IDX_W'(count_ff - CNT_W'(1));
                  state_in = ST_MOVE;
               end else if (kind_ff == KIND_ADD) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.success = 1'b0;
                  rsp_data_in.status  = STAT_PRESENT;
                  state_in           = ST_IDLE;
               end else begin
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.success = 1'b1;
                  rsp_data_in.status  = STAT_OK;
                  state_in           = ST_IDLE;
               end
            end else if (last) begin
               do_miss  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // Advance to the next stored entry.
               idx_in  = idx_ff + IDX_W'(1);
               rd_addr = idx_ff + IDX_W'(1);
            end
         end
         ST_MOVE: begin
            wr.en              = 1'b1;
            wr.addr            = pos_ff;
            wr.data            = rd_data;
            count_in           = count_ff - CNT_W'(1);
            rsp_strobe_in      = 1'b1;
            rsp_data_in.success = 1'b1;
            rsp_data_in.status  = STAT_OK;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_miss) begin
         rsp_strobe_in = 1'b1;
         if (miss_kind == KIND_ADD) begin
            if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
               rsp_data_in.success = 1'b0;
               rsp_data_in.status  = STAT_FULL;
            end else begin
               // Append at the end of the list.
               wr.en               = 1'b1;
               wr.addr             = IDX_W'(count_ff);
               wr.data             = miss_id;
               count_in            = count_ff + CNT_W'(1);
               rsp_data_in.success = 1'b1;
               rsp_data_in.status  = STAT_OK;
            end
         end else begin
            rsp_data_in.success = 1'b0;
            rsp_data_in.status  = STAT_NOT_FOUND;
         end
      end

      if (rsp_strobe_in) begin
         rsp_data_in.stored_count = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Hold request payload and scan pointers; no reset needed.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Count reported never exceeds the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.stored_count <= 5'(MAX_ENTRIES)))
      else $error("stored_count beyond table depth");

   // Success and status agree.
   a_success_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.success == (rsp_data.status == STAT_OK)))
      else $error("success does not match status");

   // Leaving a busy request always produces its response.
   a_done_has_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("request finished without a response");

   // A response only shows once the sequencer is back in idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while a scan is still running");

endmodule
